[hdl/dtrd_pkg.sv]
package dtrd_pkg;

    localparam int NUM_CLASSES  = 4;
    localparam int CLASS_FIELDS = 4;
    localparam int USED_CLASSES = (NUM_CLASSES < CLASS_FIELDS) ? NUM_CLASSES : CLASS_FIELDS;

    localparam int COORD_W = 32;
    localparam int SCORE_W = 17;
    localparam int PIX_W   = 12;
    localparam int CLS_W   = 2;
    localparam int WIDE_W  = COORD_W + PIX_W + 1;   // signed coord times unsigned frame size
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    // 1.5 in Q16.16
    localparam logic signed [COORD_W-1:0] NORM_LIMIT = 32'sd98304;
    localparam logic [SCORE_W-1:0]        SCORE_MAX  = 17'h1FFFF;

    localparam logic                RST_ROW_FORMAT      = 1'b0;
    localparam logic [SCORE_W-1:0]  RST_SCORE_THRESHOLD = 17'd22938;
    localparam logic [PIX_W-1:0]    RST_IMG_WIDTH       = 12'd640;
    localparam logic [PIX_W-1:0]    RST_IMG_HEIGHT      = 12'd480;

    typedef enum logic [1:0] {
        REG_ROW_FORMAT      = 2'd0,
        REG_SCORE_THRESHOLD = 2'd1,
        REG_IMG_WIDTH       = 2'd2,
        REG_IMG_HEIGHT      = 2'd3
    } t_reg_idx;

    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] box_w_in;
        logic signed [COORD_W-1:0] box_h_in;
        logic [SCORE_W-1:0]        objectness;
        logic [SCORE_W-1:0]        class_score_0;
        logic [SCORE_W-1:0]        class_score_1;
        logic [SCORE_W-1:0]        class_score_2;
        logic [SCORE_W-1:0]        class_score_3;
        logic signed [7:0]         class_index;
    } t_row;

    typedef struct packed {
        logic               keep;
        logic [CLS_W-1:0]   obj_class;
        logic [SCORE_W-1:0] score;
        logic [PIX_W-1:0]   left;
        logic [PIX_W-1:0]   top;
        logic [PIX_W-1:0]   out_width;
        logic [PIX_W-1:0]   out_height;
    } t_result;

endpackage

[hdl/dtrd_row_if.sv]
interface dtrd_row_if;
    logic          valid;
    logic          ready;
    dtrd_pkg::t_row data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/dtrd_res_if.sv]
interface dtrd_res_if;
    logic             valid;
    logic             ready;
    dtrd_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/dtrd_axis.sv]
module dtrd_axis (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  dtrd_pkg::t_wide             i_centre,
    input  dtrd_pkg::t_wide             i_size,
    input  logic [dtrd_pkg::PIX_W-1:0]  i_frame,
    output logic [dtrd_pkg::PIX_W-1:0]  o_edge,
    output logic [dtrd_pkg::PIX_W-1:0]  o_len
);
    import dtrd_pkg::*;

    localparam int TE_W  = WIDE_W + 2;
    localparam int ER_W  = TE_W - 17;
    localparam int LR_W  = WIDE_W - 16;

    logic signed [TE_W-1:0] twice_edge;
    logic [ER_W-1:0]        edge_raw;
    logic [LR_W-1:0]        len_raw;
    logic [PIX_W-1:0]       hi_edge;
    logic [PIX_W:0]         hi_len;
    logic [PIX_W-1:0]       n_edge;
    logic [PIX_W:0]         n_len;
    logic [PIX_W-1:0]       r_edge;
    logic [PIX_W:0]         r_len;
    logic [PIX_W:0]         len_clamped;

    // edge at 17 fractional bits; negative edges clamp to zero so truncation is a plain shift
    always_comb begin
        twice_edge = {i_centre[WIDE_W-1], i_centre, 1'b0} - TE_W'(i_size);
        edge_raw   = twice_edge[TE_W-1:17];
        len_raw    = i_size[WIDE_W-1:16];
        hi_edge    = (i_frame == '0) ? '0 : i_frame - PIX_W'(1);

        if (twice_edge[TE_W-1]) begin
            n_edge = '0;
        end else if (edge_raw > ER_W'(hi_edge)) begin
            n_edge = hi_edge;
        end else begin
            n_edge = edge_raw[PIX_W-1:0];
        end

        // saturate to one past the largest frame; the final clamp is done next stage
        if (i_size[WIDE_W-1]) begin
            n_len = '0;
        end else if (len_raw > LR_W'({PIX_W{1'b1}})) begin
            n_len = {1'b1, {PIX_W{1'b0}}};
        end else begin
            n_len = len_raw[PIX_W:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_edge <= n_edge;
            r_len  <= n_len;
        end
    end

    always_comb begin
        hi_len = (i_frame == '0) ? (PIX_W+1)'(1) : {1'b0, i_frame} - {1'b0, r_edge};
        if (r_len == '0) begin
            len_clamped = (PIX_W+1)'(1);
        end else if (r_len > hi_len) begin
            len_clamped = hi_len;
        end else begin
            len_clamped = r_len;
        end
        o_edge = r_edge;
        o_len  = len_clamped[PIX_W-1:0];
    end

endmodule

[hdl/detection_row_decoder_top.sv]
// Detection row decoder.
// i_row carries one detector output row per request (valid/ready); o_res returns
// exactly one result per row, in order. keep = 0 marks a rejected row, and then every
// other result field is zero.
// Throughput: one row per cycle while o_res is not stalled, set by a four-stage
// pipeline (class pick and range checks, the five multipliers, score saturation with
// edge computation, length clamp into the output register).
// Stalls: each stage moves when the stage after it is empty or moving, so the block
// keeps taking rows into empty stages while a result waits on o_res; nothing is dropped
// or duplicated.
// Configuration: APB port, registers at 0x0 row format, 0x4 score threshold,
// 0x8 image width, 0xC image height. Write only while no row is in flight.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the register
// defaults: class-score mode, threshold 22938, frame 640 x 480.
module detection_row_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dtrd_row_if.sink                      i_row,
    dtrd_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtrd_pkg::APB_AW-1:0]   paddr,
    input  logic [dtrd_pkg::APB_DW-1:0]   pwdata,
    output logic [dtrd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import dtrd_pkg::*;

    // configuration
    logic               r_row_format;
    logic [SCORE_W-1:0] r_score_threshold;
    logic [PIX_W-1:0]   r_img_width;
    logic [PIX_W-1:0]   r_img_height;
    t_reg_idx           reg_idx;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_format      <= RST_ROW_FORMAT;
            r_score_threshold <= RST_SCORE_THRESHOLD;
            r_img_width       <= RST_IMG_WIDTH;
            r_img_height      <= RST_IMG_HEIGHT;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_ROW_FORMAT:      r_row_format      <= pwdata[0];
                REG_SCORE_THRESHOLD: r_score_threshold <= pwdata[SCORE_W-1:0];
                REG_IMG_WIDTH:       r_img_width       <= pwdata[PIX_W-1:0];
                REG_IMG_HEIGHT:      r_img_height      <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_FORMAT:      prdata = APB_DW'(r_row_format);
            REG_SCORE_THRESHOLD: prdata = APB_DW'(r_score_threshold);
            REG_IMG_WIDTH:       prdata = APB_DW'(r_img_width);
            REG_IMG_HEIGHT:      prdata = APB_DW'(r_img_height);
            default:             prdata = '0;
        endcase
    end

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || o_res.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_row.ready = en1;
    assign o_res.valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_row.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: best class, class and size checks, normalized test
    logic [SCORE_W-1:0] cls_scores [CLASS_FIELDS];
    logic [SCORE_W-1:0] n1_best;
    logic [CLS_W-1:0]   n1_cls;
    logic               n1_cls_ok;
    logic               n1_norm;
    t_row               row;

    logic signed [COORD_W-1:0] r1_cx, r1_cy, r1_w, r1_h;
    logic [SCORE_W-1:0]        r1_obj, r1_best;
    logic [CLS_W-1:0]          r1_cls;
    logic                      r1_ok;
    logic                      r1_norm;

    assign row = i_row.data;

    always_comb begin
        cls_scores[0] = row.class_score_0;
        cls_scores[1] = row.class_score_1;
        cls_scores[2] = row.class_score_2;
        cls_scores[3] = row.class_score_3;
        n1_best = cls_scores[0];
        n1_cls  = '0;
        for (int i = 1; i < USED_CLASSES; i++) begin
            if (cls_scores[i] > n1_best) begin
                n1_best = cls_scores[i];
                n1_cls  = CLS_W'(i);
            end
        end
        n1_cls_ok = 1'b1;
        if (r_row_format) begin
            n1_cls    = row.class_index[CLS_W-1:0];
            n1_cls_ok = (row.class_index >= 8'sd0) &&
                        (row.class_index < 8'(USED_CLASSES));
        end
        n1_norm = (row.center_x <= NORM_LIMIT) && (row.center_y <= NORM_LIMIT) &&
                  (row.box_w_in <= NORM_LIMIT) && (row.box_h_in <= NORM_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cx   <= row.center_x;
            r1_cy   <= row.center_y;
            r1_w    <= row.box_w_in;
            r1_h    <= row.box_h_in;
            r1_obj  <= row.objectness;
            r1_best <= n1_best;
            r1_cls  <= n1_cls;
            r1_ok   <= n1_cls_ok && (row.box_w_in > 32'sd0) && (row.box_h_in > 32'sd0);
            r1_norm <= n1_norm;
        end
    end

    // stage 2: score product and scaling to the frame
    logic signed [PIX_W:0] fw_s, fh_s;
    t_wide                 m_cx, m_cy, m_w, m_h;
    logic [2*SCORE_W-1:0]  r2_prod;
    t_wide                 r2_cx, r2_cy, r2_w, r2_h;
    logic [CLS_W-1:0]      r2_cls;
    logic                  r2_ok;

    assign fw_s = $signed({1'b0, r_img_width});
    assign fh_s = $signed({1'b0, r_img_height});
    assign m_cx = r1_cx * fw_s;
    assign m_cy = r1_cy * fh_s;
    assign m_w  = r1_w * fw_s;
    assign m_h  = r1_h * fh_s;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            // pre-scored rows pass the score through the same >>16 as the product
            r2_prod <= r_row_format ? {1'b0, r1_obj, 16'd0} : r1_obj * r1_best;
            r2_cx   <= r1_norm ? m_cx : WIDE_W'(r1_cx);
            r2_cy   <= r1_norm ? m_cy : WIDE_W'(r1_cy);
            // a zero height register forces the scaled width to zero as well
            r2_w    <= r1_norm ? ((r_img_height == '0) ? '0 : m_w) : WIDE_W'(r1_w);
            r2_h    <= r1_norm ? m_h : WIDE_W'(r1_h);
            r2_cls  <= r1_cls;
            r2_ok   <= r1_ok;
        end
    end

    // stage 3: score saturation and threshold; edges in the axis units
    logic [SCORE_W:0]   s_full;
    logic [SCORE_W-1:0] n3_score;
    logic               r3_keep;
    logic [CLS_W-1:0]   r3_cls;
    logic [SCORE_W-1:0] r3_score;
    logic [PIX_W-1:0]   x_edge, x_len, y_edge, y_len;

    assign s_full   = r2_prod[2*SCORE_W-1:16];
    assign n3_score = s_full[SCORE_W] ? SCORE_MAX : s_full[SCORE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_keep  <= r2_ok && (n3_score >= r_score_threshold);
            r3_cls   <= r2_cls;
            r3_score <= n3_score;
        end
    end

    dtrd_axis u_axis_x (
        .i_clk    (i_clk),
        .i_en     (en3),
        .i_centre (r2_cx),
        .i_size   (r2_w),
        .i_frame  (r_img_width),
        .o_edge   (x_edge),
        .o_len    (x_len)
    );

    dtrd_axis u_axis_y (
        .i_clk    (i_clk),
        .i_en     (en3),
        .i_centre (r2_cy),
        .i_size   (r2_h),
        .i_frame  (r_img_height),
        .o_edge   (y_edge),
        .o_len    (y_len)
    );

    // stage 4: output register, rejected rows read as all zero
    t_result r4_res;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            if (r3_keep) begin
                r4_res.keep       <= 1'b1;
                r4_res.obj_class  <= r3_cls;
                r4_res.score      <= r3_score;
                r4_res.left       <= x_edge;
                r4_res.top        <= y_edge;
                r4_res.out_width  <= x_len;
                r4_res.out_height <= y_len;
            end else begin
                r4_res <= '0;
            end
        end
    end

    assign o_res.data = r4_res;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && !r4_res.keep |-> (r4_res.obj_class == '0) && (r4_res.score == '0) &&
            (r4_res.left == '0) && (r4_res.top == '0) &&
            (r4_res.out_width == '0) && (r4_res.out_height == '0))
        else $error("rejected row with nonzero fields");

    a_size_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r4_res.keep |-> (r4_res.out_width != '0) && (r4_res.out_height != '0))
        else $error("kept box with zero size");

    a_box_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r4_res.keep && (r_img_width != '0) |->
            ({1'b0, r4_res.left} + {1'b0, r4_res.out_width} <= {1'b0, r_img_width}))
        else $error("box extends past frame width");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_row.valid && i_row.ready) |-> r_v1)
        else $error("accepted row lost at stage one");

endmodule
